// File: design/lcsg_pkg.sv
// Shared constants, types and the sine table generator for the chirp sample generator.
`default_nettype none

package lcsg_pkg;

    // Default values of the top-level parameters.
    localparam int unsigned PHASE_WIDTH_DEF        = 32;
    localparam int unsigned TABLE_ADDRESS_BITS_DEF = 10;
    localparam int unsigned SAMPLE_WIDTH_DEF       = 16;
    localparam int unsigned COUNT_WIDTH_DEF        = 24;

    // Fixed field widths.
    localparam int unsigned INDEX_WIDTH     = 24;
    localparam int unsigned CFG_INDEX_WIDTH = 2;
    localparam int unsigned CFG_DATA_WIDTH  = 32;
    localparam int unsigned START_WIDTH     = 32;
    localparam int unsigned CURVE_WIDTH     = 32;
    localparam int unsigned LIMIT_WIDTH     = 24;

    // Register reset values.
    localparam logic [START_WIDTH-1:0] START_INCREMENT_RESET = 32'd9739155;
    localparam logic [CURVE_WIDTH-1:0] SWEEP_CURVATURE_RESET = 32'd1988;
    localparam logic [LIMIT_WIDTH-1:0] SAMPLE_COUNT_RESET    = 24'd44100;

    // Depth of the queue between front and back (power of two).
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_START_INCREMENT = 2'd0,
        CFG_SWEEP_CURVATURE = 2'd1,
        CFG_SAMPLE_COUNT    = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // Quarter-wave entry: integer Taylor series in Q30, Horner form, truncating
    // shifts and divisions, rounded half up and clamped to the amplitude.
    // Evaluated at elaboration only.
    function automatic logic [63:0] sine_entry(input int unsigned idx,
                                               input int unsigned tab_bits,
                                               input int unsigned amp_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] p;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] amp;
        amp  = (64'd1 << amp_bits) - 64'd1;
        x    = (HALF_PI_Q30 * (64'(idx) * 64'd2 + 64'd1)) >> (tab_bits + 1);
        x2   = (x * x) >> 30;
        t    = Q30_ONE;
        term = 64'd0;
        for (int k = 0; k < 6; k++) begin
            p = (x2 * t) >> 30;
            case (k)
                0:       term = p / 64'd156;
                1:       term = p / 64'd110;
                2:       term = p / 64'd72;
                3:       term = p / 64'd42;
                4:       term = p / 64'd20;
                default: term = p / 64'd6;
            endcase
            t = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
        end
        s = (x * t) >> 30;
        v = (s * amp + (Q30_ONE >> 1)) >> 30;
        return (v > amp) ? amp : v;
    endfunction

endpackage

`default_nettype wire

// File: design/linear_chirp_sample_generator_core.sv
// Top level of the linear chirp sample generator: front end, request queue and sine back end.
//
// Usage:
//   Slave stream: each request carries one flag in s_axis_tdata[0]: 0 asks for the next
//   chirp sample, 1 ends the chirp at once. Master stream: one sample per emitting request,
//   sample value and index in m_axis_tdata, tlast high on the final sample of the chirp.
//   Configuration: i_cfg_index 0 start increment, 1 sweep curvature (signed),
//   2 sample count; write only while no request is in flight. o_cfg_ready is always high.
// Path: a sample passes the queue write, the table read and the output register on
//   its way to the master side. Throughput is one request per cycle while the queue has
//   room, set by the phase update in the front end and the registered table read.
// Reset: clears the accumulators, the counter and the finished flag, restores the
//   register defaults and empties the queue and output stages; the sine table is constant.
// Stall: a stalled receiver holds the output register; the back end stops drawing from
//   the four-entry queue, and s_axis_tready drops once the queue is full. Requests that
//   yield no sample (stop, chirp over) are taken whenever the queue has room.
`default_nettype none

module linear_chirp_sample_generator_core #(
    parameter int unsigned PHASE_WIDTH        = lcsg_pkg::PHASE_WIDTH_DEF,
    parameter int unsigned TABLE_ADDRESS_BITS = lcsg_pkg::TABLE_ADDRESS_BITS_DEF,
    parameter int unsigned SAMPLE_WIDTH       = lcsg_pkg::SAMPLE_WIDTH_DEF,
    parameter int unsigned COUNT_WIDTH        = lcsg_pkg::COUNT_WIDTH_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // request stream
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire  [7:0]                            s_axis_tdata,  // [0] stop_request
    // sample stream
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // sample_value, then sample_index (24 bits), zero padded to bytes
    output logic [((SAMPLE_WIDTH + lcsg_pkg::INDEX_WIDTH + 7) / 8) * 8 - 1:0]
                                                  m_axis_tdata,
    output logic                                  m_axis_tlast,  // last_sample
    // configuration writes
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [lcsg_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  wire  [lcsg_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data
);

    localparam int unsigned OutDataWidth =
        ((SAMPLE_WIDTH + lcsg_pkg::INDEX_WIDTH + 7) / 8) * 8;
    localparam int unsigned EntryWidth =
        TABLE_ADDRESS_BITS + 2 + lcsg_pkg::INDEX_WIDTH + 1;

    lcsg_pkg::t_queue_status          w_queue_status;
    logic                             w_push;
    logic                             w_pop;
    logic [EntryWidth-1:0]            w_entry;
    logic [EntryWidth-1:0]            w_head;
    logic signed [SAMPLE_WIDTH-1:0]   w_sample_value;
    logic [lcsg_pkg::INDEX_WIDTH-1:0] w_sample_index;

    // Classify requests and advance the phase.
    lcsg_front #(
        .PHASE_WIDTH        (PHASE_WIDTH),
        .TABLE_ADDRESS_BITS (TABLE_ADDRESS_BITS),
        .COUNT_WIDTH        (COUNT_WIDTH),
        .ENTRY_WIDTH        (EntryWidth)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick_valid   (s_axis_tvalid),
        .o_tick_ready   (s_axis_tready),
        .i_stop_request (s_axis_tdata[0]),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_queue_status (w_queue_status),
        .o_push         (w_push),
        .o_entry        (w_entry)
    );

    // Hold pending samples while the back end is stalled.
    lcsg_queue #(
        .WIDTH (EntryWidth)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_entry),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_queue_status)
    );

    // Look up the sine and drive the output register.
    lcsg_back #(
        .TABLE_ADDRESS_BITS (TABLE_ADDRESS_BITS),
        .SAMPLE_WIDTH       (SAMPLE_WIDTH),
        .ENTRY_WIDTH        (EntryWidth)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_queue_status (w_queue_status),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_sample_value (w_sample_value),
        .o_sample_index (w_sample_index),
        .o_last_sample  (m_axis_tlast)
    );

    // Pack value low, index above it, zero padding on top.
    assign m_axis_tdata = OutDataWidth'({w_sample_index, w_sample_value});

endmodule

`default_nettype wire

// File: design/lcsg_queue.sv
// Short request queue between the phase front end and the sine back end.
`default_nettype none

module lcsg_queue #(
    parameter int unsigned WIDTH = 37
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_push,
    input  wire  [WIDTH-1:0]           i_entry,
    input  wire                        i_pop,
    output logic [WIDTH-1:0]           o_head,
    output lcsg_pkg::t_queue_status    o_status
);

    localparam int unsigned Depth  = lcsg_pkg::QUEUE_DEPTH;
    localparam int unsigned PtrW   = $clog2(Depth);
    localparam int unsigned CountW = $clog2(Depth + 1);

    logic [WIDTH-1:0]  r_mem [Depth];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [CountW-1:0] r_count;
    logic [PtrW-1:0]   n_wr_ptr;
    logic [PtrW-1:0]   n_rd_ptr;
    logic [CountW-1:0] n_count;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + PtrW'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + PtrW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CountW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CountW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CountW'(Depth));
    assign o_status.empty = (r_count == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push || i_pop)
        else $error("request queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.empty |-> !i_pop)
        else $error("request queue read while empty");

endmodule

`default_nettype wire

// File: design/lcsg_front.sv
// Front end: configuration registers, tick classification and phase accumulation.
`default_nettype none

module lcsg_front #(
    parameter int unsigned PHASE_WIDTH        = lcsg_pkg::PHASE_WIDTH_DEF,
    parameter int unsigned TABLE_ADDRESS_BITS = lcsg_pkg::TABLE_ADDRESS_BITS_DEF,
    parameter int unsigned COUNT_WIDTH        = lcsg_pkg::COUNT_WIDTH_DEF,
    parameter int unsigned ENTRY_WIDTH        = TABLE_ADDRESS_BITS + 2
                                                + lcsg_pkg::INDEX_WIDTH + 1
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // tick requests
    input  wire                                   i_tick_valid,
    output logic                                  o_tick_ready,
    input  wire                                   i_stop_request,
    // configuration writes
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [lcsg_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  wire  [lcsg_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data,
    // queue side
    input  lcsg_pkg::t_queue_status               i_queue_status,
    output logic                                  o_push,
    output logic [ENTRY_WIDTH-1:0]                o_entry
);

    localparam int unsigned TopBits = TABLE_ADDRESS_BITS + 2;

    logic [lcsg_pkg::START_WIDTH-1:0]        r_start_increment;
    logic signed [lcsg_pkg::CURVE_WIDTH-1:0] r_sweep_curvature;
    logic [lcsg_pkg::LIMIT_WIDTH-1:0]        r_sample_count;

    logic [PHASE_WIDTH-1:0] r_phase;
    logic [PHASE_WIDTH-1:0] r_sweep;
    logic [COUNT_WIDTH-1:0] r_counter;
    logic                   r_finished;
    logic [PHASE_WIDTH-1:0] n_phase;
    logic [PHASE_WIDTH-1:0] n_sweep;
    logic [COUNT_WIDTH-1:0] n_counter;
    logic                   n_finished;

    logic                   w_accept;
    logic                   w_run_out;
    logic                   w_emit;
    logic                   w_last;
    logic [COUNT_WIDTH-1:0] w_limit;
    logic [PHASE_WIDTH-1:0] w_curv;

    assign o_tick_ready = !i_queue_status.full;
    assign o_cfg_ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_increment <= lcsg_pkg::START_INCREMENT_RESET;
            r_sweep_curvature <= lcsg_pkg::SWEEP_CURVATURE_RESET;
            r_sample_count    <= lcsg_pkg::SAMPLE_COUNT_RESET;
        end else if (i_cfg_valid) begin
            case (lcsg_pkg::t_cfg_index'(i_cfg_index))
                lcsg_pkg::CFG_START_INCREMENT: r_start_increment <= i_cfg_data;
                lcsg_pkg::CFG_SWEEP_CURVATURE: r_sweep_curvature <= i_cfg_data;
                lcsg_pkg::CFG_SAMPLE_COUNT:
                    r_sample_count <= i_cfg_data[lcsg_pkg::LIMIT_WIDTH-1:0];
                default: ; // drop writes to unknown registers
            endcase
        end
    end

    // Classify the tick: stop, run out, or emit one sample.
    always_comb begin
        w_accept  = i_tick_valid && o_tick_ready;
        w_limit   = COUNT_WIDTH'(r_sample_count);
        w_run_out = (r_counter >= w_limit);
        w_emit    = w_accept && !r_finished && !i_stop_request && !w_run_out;
        w_last    = ((r_counter + COUNT_WIDTH'(1)) == w_limit);
        w_curv    = PHASE_WIDTH'(r_sweep_curvature);
    end

    always_comb begin
        n_phase    = r_phase;
        n_sweep    = r_sweep;
        n_counter  = r_counter;
        n_finished = r_finished;
        if (w_accept && !r_finished && (i_stop_request || w_run_out)) begin
            n_finished = 1'b1;
        end
        if (w_emit) begin
            n_phase   = r_phase + PHASE_WIDTH'(r_start_increment) + r_sweep + w_curv;
            n_sweep   = r_sweep + {w_curv[PHASE_WIDTH-2:0], 1'b0};
            n_counter = r_counter + COUNT_WIDTH'(1);
            if (w_last) begin
                n_finished = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_sweep    <= '0;
            r_counter  <= '0;
            r_finished <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_sweep    <= n_sweep;
            r_counter  <= n_counter;
            r_finished <= n_finished;
        end
    end

    assign o_push  = w_emit;
    assign o_entry = {w_last, lcsg_pkg::INDEX_WIDTH'(r_counter),
                      r_phase[PHASE_WIDTH-1 -: TopBits]};

    a_silent_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> !o_push)
        else $error("sample issued after the chirp finished");

    a_last_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_entry[ENTRY_WIDTH-1] |=> r_finished)
        else $error("last sample did not end the chirp");

endmodule

`default_nettype wire

// File: design/lcsg_back.sv
// Back end: quarter-wave sine lookup, quadrant folding and the output register.
`default_nettype none

module lcsg_back #(
    parameter int unsigned TABLE_ADDRESS_BITS = lcsg_pkg::TABLE_ADDRESS_BITS_DEF,
    parameter int unsigned SAMPLE_WIDTH       = lcsg_pkg::SAMPLE_WIDTH_DEF,
    parameter int unsigned ENTRY_WIDTH        = TABLE_ADDRESS_BITS + 2
                                                + lcsg_pkg::INDEX_WIDTH + 1
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // queue side
    input  lcsg_pkg::t_queue_status             i_queue_status,
    input  wire  [ENTRY_WIDTH-1:0]              i_head,
    output logic                                o_pop,
    // result side
    output logic                                o_valid,
    input  wire                                 i_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      o_sample_value,
    output logic [lcsg_pkg::INDEX_WIDTH-1:0]    o_sample_index,
    output logic                                o_last_sample
);

    localparam int unsigned TableDepth = 1 << TABLE_ADDRESS_BITS;
    localparam int unsigned MagWidth   = SAMPLE_WIDTH - 1;
    localparam int unsigned IdxLow     = TABLE_ADDRESS_BITS + 2;

    logic [MagWidth-1:0] w_rom [TableDepth];

    for (genvar g = 0; g < TableDepth; g++) begin : g_rom
        localparam logic [63:0] Entry =
            lcsg_pkg::sine_entry(g, TABLE_ADDRESS_BITS, MagWidth);
        assign w_rom[g] = Entry[MagWidth-1:0];
    end

    logic [TABLE_ADDRESS_BITS-1:0] w_addr;
    logic [1:0]                    w_quadrant;
    logic                          w_s1_adv;
    logic [SAMPLE_WIDTH-1:0]       w_mag_ext;

    logic                              r_s1_valid;
    logic [MagWidth-1:0]               r_s1_mag;
    logic                              r_s1_neg;
    logic [lcsg_pkg::INDEX_WIDTH-1:0]  r_s1_index;
    logic                              r_s1_last;
    logic                              r_out_valid;
    logic [SAMPLE_WIDTH-1:0]           r_out_value;
    logic [lcsg_pkg::INDEX_WIDTH-1:0]  r_out_index;
    logic                              r_out_last;

    // Fold the address in odd quadrants and decide when to draw from the queue.
    always_comb begin
        w_quadrant = i_head[TABLE_ADDRESS_BITS+1:TABLE_ADDRESS_BITS];
        w_addr     = w_quadrant[0] ? ~i_head[TABLE_ADDRESS_BITS-1:0]
                                   : i_head[TABLE_ADDRESS_BITS-1:0];
        w_s1_adv   = !r_out_valid || i_ready;
        o_pop      = !i_queue_status.empty && (!r_s1_valid || w_s1_adv);
        w_mag_ext  = {1'b0, r_s1_mag};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (r_s1_valid && w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_mag   <= w_rom[w_addr];
            r_s1_neg   <= w_quadrant[1];
            r_s1_index <= i_head[IdxLow +: lcsg_pkg::INDEX_WIDTH];
            r_s1_last  <= i_head[ENTRY_WIDTH-1];
        end
        if (r_s1_valid && w_s1_adv) begin
            r_out_value <= r_s1_neg ? (~w_mag_ext + SAMPLE_WIDTH'(1)) : w_mag_ext;
            r_out_index <= r_s1_index;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sample_value = r_out_value;
    assign o_sample_index = r_out_index;
    assign o_last_sample  = r_out_last;

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the linear chirp sample generator core.

module testbench;

    // Predictor geometry: 32-bit phase, 1024-entry quarter wave, Q1.15 samples.
    localparam int          ADDR_BITS        = 10;
    localparam int          TABLE_DEPTH      = 1 << ADDR_BITS;
    localparam logic [63:0] ONE_Q30          = 64'd1 << 30;
    localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;  // pi/2 in Q30
    localparam logic [63:0] PEAK             = 64'd32767;

    // Allow plenty of margin when settling after the last sample is back.
    localparam int DRAIN_CYCLES     = 8;
    localparam int DIRECTED_ROWS    = 24;
    localparam int RANDOM_SEGMENTS  = 12;   // four register settings per idling pattern
    localparam int SEGMENT_REQUESTS = 85;
    localparam int TAIL_SAMPLES     = 12;

    // Register index with no register behind it.
    localparam logic [1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [15:0] amplitude;
        logic [23:0] index;
        logic        is_last;
    } chirp_sample_t;

    typedef struct packed {
        logic          is_write;
        logic [1:0]    reg_sel;
        logic [31:0]   wdata;
        logic          stop;
        logic          typed;
        chirp_sample_t expected;
    } plan_row_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [0] stop_request
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [39:0] m_axis_tdata;           // [15:0] sample_value, [39:16] sample_index
    wire         m_axis_tlast;           // last_sample
    logic        i_cfg_valid   = 1'b0;
    wire         o_cfg_ready;
    logic [1:0]  i_cfg_index   = 2'd0;
    logic [31:0] i_cfg_data    = 32'd0;

    // Predictor copy of the registers and of the generator state.
    logic [14:0] quarter_wave [TABLE_DEPTH];
    logic [31:0] start_step   = lcsg_pkg::START_INCREMENT_RESET;
    logic [31:0] curvature    = lcsg_pkg::SWEEP_CURVATURE_RESET;
    logic [23:0] chirp_length = lcsg_pkg::SAMPLE_COUNT_RESET;
    logic [31:0] phase        = 32'd0;
    logic [31:0] sweep        = 32'd0;
    logic [23:0] emitted      = 24'd0;
    logic        chirp_over   = 1'b0;

    chirp_sample_t pending_samples [$];
    int            mismatch_count = 0;
    int            src_idle_pct   = 33;
    int            sink_idle_pct  = 71;

    linear_chirp_sample_generator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Quarter-wave entry i: sine at the centre of slot i, Q30 series in Horner
    // form with truncating steps, scaled to the peak, rounded half up, clamped.
    function automatic logic [14:0] quarter_wave_entry(input int unsigned i);
        logic [63:0] ang;
        logic [63:0] ang_sq;
        logic [63:0] acc;
        logic [63:0] reduced;
        logic [63:0] level;
        ang    = (QUARTER_TURN_Q30 * (64'(i) * 64'd2 + 64'd1)) / (64'd2 * 64'(TABLE_DEPTH));
        ang_sq = (ang * ang) >> 30;
        acc    = ONE_Q30;
        // innermost term first: each level divides by (2m)(2m+1)
        for (int m = 6; m >= 1; m--) begin
            reduced = ((ang_sq * acc) >> 30) / (64'(2 * m) * 64'(2 * m + 1));
            acc     = (reduced >= ONE_Q30) ? 64'd0 : ONE_Q30 - reduced;
        end
        level = ((((ang * acc) >> 30) * PEAK) + (ONE_Q30 >> 1)) >> 30;
        return (level > PEAK) ? PEAK[14:0] : level[14:0];
    endfunction

    // Advance the chirp by one request; return 1 when a sample is emitted.
    function automatic logic advance_chirp(input logic stop, output chirp_sample_t result);
        logic [1:0]           quadrant;
        logic [ADDR_BITS-1:0] addr;
        logic [15:0]          magnitude;
        result = '0;
        if (chirp_over)
            return 1'b0;
        // a stop, or a length already reached, ends the chirp silently
        if (stop || emitted >= chirp_length) begin
            chirp_over = 1'b1;
            return 1'b0;
        end
        quadrant         = phase[31:30];
        addr             = quadrant[0] ? ~phase[29:20] : phase[29:20];
        magnitude        = {1'b0, quarter_wave[addr]};
        result.amplitude = quadrant[1] ? -magnitude : magnitude;
        result.index     = emitted;
        result.is_last   = ({1'b0, emitted} + 25'd1) == {1'b0, chirp_length};
        // second-order phase: step grows by twice the curvature every sample
        phase   = phase + start_step + sweep + curvature;
        sweep   = sweep + {curvature[30:0], 1'b0};
        emitted = emitted + 24'd1;
        if (result.is_last)
            chirp_over = 1'b1;
        return 1'b1;
    endfunction

    // Directed rows: writes, plain requests, and the one sample readable by eye.
    function automatic plan_row_t directed_row(input int r);
        plan_row_t row;
        row = '0;
        case (r)
            // first sample after reset sits at phase zero: smallest table entry
            0:  row = {1'b0, 2'd0, 32'd0, 1'b0, 1'b1, 16'd25, 24'd0, 1'b0};
            // freeze the start step and the curvature
            3:  row = {1'b1, lcsg_pkg::CFG_START_INCREMENT, 32'h0000_0000, 2'b00, 41'd0};
            4:  row = {1'b1, lcsg_pkg::CFG_SWEEP_CURVATURE, 32'h0000_0000, 2'b00, 41'd0};
            // a quarter turn per sample walks every quadrant
            7:  row = {1'b1, lcsg_pkg::CFG_START_INCREMENT, 32'h4000_0000, 2'b00, 41'd0};
            12: row = {1'b1, lcsg_pkg::CFG_START_INCREMENT, 32'hFFFF_FFFF, 2'b00, 41'd0};
            13: row = {1'b1, lcsg_pkg::CFG_SWEEP_CURVATURE, 32'h8000_0000, 2'b00, 41'd0};
            16: row = {1'b1, lcsg_pkg::CFG_SWEEP_CURVATURE, 32'h7FFF_FFFF, 2'b00, 41'd0};
            // upper byte beyond the count field must be dropped
            19: row = {1'b1, lcsg_pkg::CFG_SAMPLE_COUNT, 32'hFFFF_FFFF, 2'b00, 41'd0};
            20: row = {1'b1, CFG_SPARE, 32'hA5C3_0F96, 2'b00, 41'd0};
            default: ;
        endcase
        return row;
    endfunction

    function automatic logic [31:0] pick_start();
        case ($urandom_range(0, 4))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(0, 32'h0400_0000);   // audio-band tones
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_curvature();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return $urandom_range(0, 8000) - 32'd4000;  // gentle sweep either way
            default: return $urandom;
        endcase
    endfunction

    // Keep the length well ahead of the counter so the chirp runs on.
    function automatic logic [31:0] pick_length();
        logic [7:0]  junk;
        logic [23:0] span;
        junk = 8'($urandom);
        if ($urandom_range(0, 3) == 0)
            span = 24'hFF_FFFF;
        else
            span = 24'($urandom_range(32'hFF_FFFF, 32'(emitted) + 32'd2000));
        return {junk, span};
    endfunction

    // Offer one request, hold it until taken, then record what it should yield.
    task automatic send_request(input logic stop, input logic typed,
                                input chirp_sample_t typed_result);
        chirp_sample_t predicted;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, stop};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (advance_chirp(stop, predicted))
            pending_samples = {pending_samples, (typed ? typed_result : predicted)};
    endtask

    // Drop the request stream and wait until every sample is back.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] sel, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (sel)
            lcsg_pkg::CFG_START_INCREMENT: start_step   = data;
            lcsg_pkg::CFG_SWEEP_CURVATURE: curvature    = data;
            lcsg_pkg::CFG_SAMPLE_COUNT:    chirp_length = data[23:0];
            default: ;  // unmapped index: nothing changes
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver stalls at the current rate.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Compare every accepted sample with the oldest one predicted.
    always @(posedge i_clk) begin : check_samples
        chirp_sample_t seen;
        chirp_sample_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = {m_axis_tdata[15:0], m_axis_tdata[39:16], m_axis_tlast};
            if (pending_samples.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected sample value %0d index %0d last %0b", $realtime,
                             $signed(seen.amplitude), seen.index, seen.is_last);
            end else begin
                want = pending_samples.pop_front();
                if (seen.amplitude !== want.amplitude || seen.index !== want.index ||
                    seen.is_last !== want.is_last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: exp value/index/last %0d/%0d/%0b, got %0d/%0d/%0b",
                                 $realtime, $signed(want.amplitude), want.index, want.is_last,
                                 $signed(seen.amplitude), seen.index, seen.is_last);
                end
            end
        end
    end

    initial begin : stimulus
        plan_row_t row;
        for (int i = 0; i < TABLE_DEPTH; i++)
            quarter_wave[i] = quarter_wave_entry(i);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: register extremes, quadrant walk, unmapped index.
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            row = directed_row(r);
            if (row.is_write) begin
                wait_idle();
                write_reg(row.reg_sel, row.wdata);
            end else begin
                send_request(row.stop, row.typed, row.expected);
            end
        end

        // Random part: one long chirp, retuned between segments while idle.
        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
            if (seg == RANDOM_SEGMENTS / 3) begin
                src_idle_pct  = 71;
                sink_idle_pct = 33;
            end
            if (seg == 2 * RANDOM_SEGMENTS / 3) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            wait_idle();
            write_reg(lcsg_pkg::CFG_START_INCREMENT, pick_start());
            write_reg(lcsg_pkg::CFG_SWEEP_CURVATURE, pick_curvature());
            write_reg(lcsg_pkg::CFG_SAMPLE_COUNT, pick_length());
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_SPARE, $urandom);
            repeat (SEGMENT_REQUESTS) send_request(1'b0, 1'b0, '0);
        end

        // Close the chirp a few samples on; the final one must carry tlast.
        wait_idle();
        write_reg(lcsg_pkg::CFG_SAMPLE_COUNT, {8'd0, emitted + 24'(TAIL_SAMPLES)});
        repeat (TAIL_SAMPLES) send_request(1'b0, 1'b0, '0);
        // Past the end nothing may come out, stop or not, whatever the length.
        send_request(1'b1, 1'b0, '0);
        repeat (8) send_request(1'($urandom_range(0, 1)), 1'b0, '0);
        wait_idle();
        write_reg(lcsg_pkg::CFG_SAMPLE_COUNT, 32'd0);
        repeat (6) send_request(1'($urandom_range(0, 1)), 1'b0, '0);
        wait_idle();

        if (mismatch_count == 0 && pending_samples.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Hang guard: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
design/lcsg_pkg.sv
design/lcsg_queue.sv
design/lcsg_front.sv
design/lcsg_back.sv
design/linear_chirp_sample_generator_core.sv
sim/testbench.sv
